[sv/pitch_class_key_mode_assert.svh]
// assertion macros for the key mode block
`ifndef PITCH_CLASS_KEY_MODE_ASSERT_SVH
`define PITCH_CLASS_KEY_MODE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCKM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pckm_pkg.sv]
package pckm_pkg;

  localparam int COUNT_BITS = 24;
  localparam int NUM_BINS   = 12;
  localparam int BIN_W      = 4;
  localparam int PROF_W     = 13;
  localparam int RECIP_W    = 16;
  localparam int PROD_W     = COUNT_BITS + PROF_W;
  localparam int ACC_W      = PROD_W + BIN_W;
  localparam int SC_W       = ACC_W + RECIP_W;
  localparam int CHAN_W     = 5;
  localparam int PITCH_W    = 7;

  typedef logic [BIN_W-1:0]          bin_idx_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic signed [PROF_W-1:0]  prof_t;
  typedef logic signed [RECIP_W-1:0] recip_t;

  localparam bin_idx_t BIN_LAST = bin_idx_t'(NUM_BINS - 1);
  localparam count_t   COUNT_MAX = '1;

  localparam logic [CHAN_W-1:0] DRUM_RESET = 5'd10;

  localparam logic CMD_NOTE = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam recip_t RECIP_MAJ = 16'sd14977;
  localparam recip_t RECIP_MIN = 16'sd16380;

  // centred profiles, 12*p - sum(p) with p in hundredths
  localparam prof_t PROF_MAJ [NUM_BINS] = '{
    13'sd3441, -13'sd1503, -13'sd3, -13'sd1383, 13'sd1077, 13'sd729,
    -13'sd1155, 13'sd2049, -13'sd1311, 13'sd213, -13'sd1431, -13'sd723
  };
  localparam prof_t PROF_MIN [NUM_BINS] = '{
    13'sd3145, -13'sd1235, -13'sd227, 13'sd2005, -13'sd1331, -13'sd215,
    -13'sd1403, 13'sd1249, 13'sd325, -13'sd1223, -13'sd443, -13'sd647
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic     note;
    logic     mac_valid;
    logic     minor;
    bin_idx_t idx;
    bin_idx_t root;
    logic     first;
    logic     last;
    logic     root_first;
    logic     scale;
    logic     decide;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // pitch mod 12 by conditional subtraction
  function automatic bin_idx_t mod12(input logic [PITCH_W-1:0] p);
    logic [PITCH_W-1:0] r;
    r = p;
    if (r >= 7'd96) r = r - 7'd96;
    if (r >= 7'd48) r = r - 7'd48;
    if (r >= 7'd24) r = r - 7'd24;
    if (r >= 7'd12) r = r - 7'd12;
    return r[BIN_W-1:0];
  endfunction

  // (idx - root) mod 12
  function automatic bin_idx_t prof_idx(input bin_idx_t idx, input bin_idx_t root);
    bin_idx_t d;
    d = idx - root;
    if (idx < root) d = d + bin_idx_t'(NUM_BINS);
    return d;
  endfunction

endpackage

[sv/pckm_if.sv]
interface pckm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [pckm_pkg::PITCH_W-1:0] pitch;
  logic [pckm_pkg::CHAN_W-1:0]  channel;

  modport source (output valid, output cmd, output pitch, output channel, input ready);
  modport sink   (input valid, input cmd, input pitch, input channel, output ready);
endinterface

interface pckm_out_if;
  logic valid;
  logic ready;
  logic is_major;
  logic had_notes;

  modport source (output valid, output is_major, output had_notes, input ready);
  modport sink   (input valid, input is_major, input had_notes, output ready);
endinterface

[sv/pitch_class_key_mode.sv]
// Major/minor key mode finder. A note request (cmd 0) on any channel other than
// drum_channel bumps one saturating pitch-class bin; back-to-back notes run at
// one per cycle while the block is idle. An evaluate request (cmd 1)
// correlates the histogram with the 12 rotations of the major and minor
// profiles on one shared multiply-accumulate unit, one term per cycle, then
// drains, scales and compares: the input is not ready from the time an
// evaluate is taken until its result is written, and longer if the
// previous result is still waiting in the output register. The evaluate
// returns one result and clears the histogram; notes do not return results.
// drum_channel may be written whenever the block is idle.
`include "pitch_class_key_mode_assert.svh"

module pitch_class_key_mode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pckm_in_if.sink                     in_i,
  pckm_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [pckm_pkg::CHAN_W-1:0] cfg_wdata_i
);

  pckm_pkg::cmd_t  ctrl_cmd;
  pckm_pkg::stat_t dp_stat;
  logic            in_ready;
  logic            out_valid, is_major, had_notes;

  pckm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  pckm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .pitch_i     (in_i.pitch),
    .channel_i   (in_i.channel),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .is_major_o  (is_major),
    .had_notes_o (had_notes)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.is_major  = is_major;
  assign out_o.had_notes = had_notes;

  `PCKM_ASSERT_NOW(a_no_accept_in_mac, ctrl_cmd.mac_valid, !in_ready, "request taken during mac")
  `PCKM_ASSERT_NOW(a_decide_free, ctrl_cmd.decide, dp_stat.out_free, "result overwritten")
  `PCKM_ASSERT_NOW(a_idx_range, ctrl_cmd.mac_valid,
                   (ctrl_cmd.idx <= pckm_pkg::BIN_LAST) && (ctrl_cmd.root <= pckm_pkg::BIN_LAST),
                   "mac index out of range")
  `PCKM_ASSERT_NEXT(a_decide_to_out, ctrl_cmd.decide, out_valid, "result not shown after decide")

endmodule

[sv/pckm_ctrl.sv]
module pckm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_cmd_i,
  output logic            in_ready_o,
  input  pckm_pkg::stat_t stat_i,
  output pckm_pkg::cmd_t  cmd_o
);

  pckm_pkg::state_e   state_q, state_d;
  pckm_pkg::bin_idx_t idx_q, idx_d;
  pckm_pkg::bin_idx_t root_q, root_d;
  logic               minor_q, minor_d;
  logic               idx_end, root_end;

  assign idx_end  = (idx_q == pckm_pkg::BIN_LAST);
  assign root_end = (root_q == pckm_pkg::BIN_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pckm_pkg::ST_IDLE;
      idx_q   <= '0;
      root_q  <= '0;
      minor_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      root_q  <= root_d;
      minor_q <= minor_d;
    end
  end

  // term counters: profile, then root, then bin
  always_comb begin
    idx_d   = idx_q;
    root_d  = root_q;
    minor_d = minor_q;
    if (state_q == pckm_pkg::ST_MAC) begin
      idx_d = idx_end ? '0 : idx_q + 4'd1;
      if (idx_end) begin
        root_d = root_end ? '0 : root_q + 4'd1;
        if (root_end) minor_d = ~minor_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pckm_pkg::ST_IDLE: begin
        if (in_valid_i && in_cmd_i == pckm_pkg::CMD_EVAL) state_d = pckm_pkg::ST_MAC;
      end
      pckm_pkg::ST_MAC: begin
        if (minor_q && root_end && idx_end) state_d = pckm_pkg::ST_DRAIN;
      end
      pckm_pkg::ST_DRAIN:  state_d = pckm_pkg::ST_SCALE;
      pckm_pkg::ST_SCALE:  state_d = pckm_pkg::ST_DECIDE;
      pckm_pkg::ST_DECIDE: begin
        if (stat_i.out_free) state_d = pckm_pkg::ST_IDLE;
      end
      default: state_d = pckm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == pckm_pkg::ST_IDLE);
    cmd_o            = '0;
    cmd_o.note       = in_ready_o && in_valid_i && (in_cmd_i == pckm_pkg::CMD_NOTE);
    cmd_o.mac_valid  = (state_q == pckm_pkg::ST_MAC);
    cmd_o.minor      = minor_q;
    cmd_o.idx        = idx_q;
    cmd_o.root       = root_q;
    cmd_o.first      = (idx_q == '0);
    cmd_o.last       = idx_end;
    cmd_o.root_first = (root_q == '0);
    cmd_o.scale      = (state_q == pckm_pkg::ST_SCALE);
    cmd_o.decide     = (state_q == pckm_pkg::ST_DECIDE) && stat_i.out_free;
  end

endmodule

[sv/pckm_dp.sv]
module pckm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pckm_pkg::cmd_t               cmd_i,
  output pckm_pkg::stat_t              stat_o,
  input  logic [pckm_pkg::PITCH_W-1:0] pitch_i,
  input  logic [pckm_pkg::CHAN_W-1:0]  channel_i,
  input  logic                         cfg_we_i,
  input  logic [pckm_pkg::CHAN_W-1:0]  cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_major_o,
  output logic                         had_notes_o
);

  pckm_pkg::count_t              bins_q [pckm_pkg::NUM_BINS];
  logic [pckm_pkg::CHAN_W-1:0]   drum_q;
  logic                          hn_q;
  logic                          count_en;
  pckm_pkg::bin_idx_t            pc;

  logic signed [pckm_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [pckm_pkg::ACC_W-1:0]  acc_q, acc_sum, best_maj_q, best_min_q;
  logic signed [pckm_pkg::SC_W-1:0]   sc_maj_q, sc_min_q;
  pckm_pkg::prof_t                    prof;
  pckm_pkg::bin_idx_t                 pidx;
  logic                               mac1_q, minor1_q, first1_q, last1_q, rfirst1_q;
  logic                               out_valid_q, is_major_q, had_notes_q;

  assign count_en = cmd_i.note && (channel_i != drum_q);
  assign pc       = pckm_pkg::mod12(pitch_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drum_q <= pckm_pkg::DRUM_RESET;
    end else if (cfg_we_i) begin
      drum_q <= cfg_wdata_i;
    end
  end

  // one saturating counter per pitch class
  for (genvar k = 0; k < pckm_pkg::NUM_BINS; k++) begin : g_bin
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bins_q[k] <= '0;
      end else if (cmd_i.decide) begin
        bins_q[k] <= '0;
      end else if (count_en && pc == pckm_pkg::bin_idx_t'(k)
                   && bins_q[k] != pckm_pkg::COUNT_MAX) begin
        bins_q[k] <= bins_q[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hn_q <= 1'b0;
    end else if (cmd_i.decide) begin
      hn_q <= 1'b0;
    end else if (count_en) begin
      hn_q <= 1'b1;
    end
  end

  // multiply stage
  assign pidx   = pckm_pkg::prof_idx(cmd_i.idx, cmd_i.root);
  assign prof   = cmd_i.minor ? pckm_pkg::PROF_MIN[pidx] : pckm_pkg::PROF_MAJ[pidx];
  assign prod_d = $signed({1'b0, bins_q[cmd_i.idx]}) * prof;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac1_q <= 1'b0;
    end else begin
      mac1_q <= cmd_i.mac_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    minor1_q  <= cmd_i.minor;
    first1_q  <= cmd_i.first;
    last1_q   <= cmd_i.last;
    rfirst1_q <= cmd_i.root_first;
  end

  // accumulate stage with running best per profile
  assign acc_sum = (first1_q ? '0 : acc_q)
                 + {{(pckm_pkg::ACC_W - pckm_pkg::PROD_W){prod_q[pckm_pkg::PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (mac1_q) begin
      acc_q <= acc_sum;
      if (last1_q && !minor1_q && (rfirst1_q || acc_sum > best_maj_q)) best_maj_q <= acc_sum;
      if (last1_q && minor1_q && (rfirst1_q || acc_sum > best_min_q)) best_min_q <= acc_sum;
    end
    if (cmd_i.scale) begin
      sc_maj_q <= best_maj_q * pckm_pkg::RECIP_MAJ;
      sc_min_q <= best_min_q * pckm_pkg::RECIP_MIN;
    end
  end

  // result register, freed when the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      is_major_q  <= (sc_maj_q >= sc_min_q);
      had_notes_q <= hn_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign is_major_o      = is_major_q;
  assign had_notes_o     = had_notes_q;

endmodule
